[rtl/tafm_pkg.sv]
// ----------------------------------------------------------------------------
// Trend amplitude and frequency meter package
// Shared widths, reset values, register indexes, states and the divider
// status bundle.
// ----------------------------------------------------------------------------
package tafm_pkg;

  // Field widths.
  localparam int SampleW = 8;
  localparam int CountW  = 4;
  localparam int PeriodW = 16;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  // Register reset values.
  localparam logic               DisplaySelRst = 1'b0;
  localparam logic [CountW-1:0]  ConfirmRst    = 4'd5;
  localparam logic [PeriodW-1:0] NumeratorRst  = 16'd2000;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_DISPLAY_SELECT = 2'd0,
    REG_CONFIRM_COUNT  = 2'd1,
    REG_FREQ_NUMERATOR = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } tafm_state_t;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } tafm_div_stat_t;

endpackage

[rtl/tafm_div.sv]
// ----------------------------------------------------------------------------
// Bit-serial saturating divider
// Restoring division of a 16-bit numerator by a 16-bit divisor, one quotient
// bit per cycle; the quotient is clamped to 255.
// ----------------------------------------------------------------------------
module tafm_div
  import tafm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PeriodW-1:0]  numerator,
  input  logic [PeriodW-1:0]  divisor,
  output tafm_div_stat_t      stat,
  output logic [SampleW-1:0]  quotient
);

  localparam int StepW = $clog2(PeriodW + 1);

  logic [PeriodW-1:0] work_r, work_nxt;
  logic [PeriodW-1:0] rem_r, rem_nxt;
  logic [PeriodW-1:0] den_r, den_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic               done_r, done_nxt;
  logic [PeriodW:0]   rem_sh;
  logic [PeriodW:0]   rem_sub;

  // One restoring step: shift in the next numerator bit and try the subtract.
  always_comb begin
    rem_sh  = {rem_r, work_r[PeriodW-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    work_nxt = work_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (start) begin
      work_nxt = numerator;
      rem_nxt  = '0;
      den_nxt  = divisor;
      step_nxt = StepW'(PeriodW);
    end else if (step_r != '0) begin
      if (!rem_sub[PeriodW]) begin
        rem_nxt  = rem_sub[PeriodW-1:0];
        work_nxt = {work_r[PeriodW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[PeriodW-1:0];
        work_nxt = {work_r[PeriodW-2:0], 1'b0};
      end
      step_nxt = step_r - StepW'(1);
      done_nxt = (step_r == StepW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  // The quotient bits have fully replaced the numerator once done is seen.
  assign quotient  = (work_r[PeriodW-1:SampleW] != '0) ? '1 : work_r[SampleW-1:0];
  assign stat.busy = (step_r != '0);
  assign stat.done = done_r;

endmodule

[rtl/trend_amplitude_frequency_meter.sv]
// ----------------------------------------------------------------------------
// Trend amplitude and frequency meter
// Follows the rising or falling trend of an ADC sample stream and reports
// amplitude and frequency on each sample.
// ----------------------------------------------------------------------------
// Each accepted sample item yields one result item. A sample that does not
// flip the trend to rising goes through the load state before the next one;
// a flip to rising starts the bit-serial divider, one quotient bit per cycle
// over the 16-bit numerator, and waits in the divide state before loading.
// A new sample is taken while the previous result still waits in the output
// register; the result is moved there once that register is free.
// Registers are written through the APB port at byte addresses 0x0
// (display_select), 0x4 (confirm_count) and 0x8 (freq_numerator).
// ----------------------------------------------------------------------------
module trend_amplitude_frequency_meter
  import tafm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SampleW-1:0] in_sample,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SampleW-1:0] out_amplitude,
  output logic [SampleW-1:0] out_frequency,
  output logic [SampleW-1:0] out_shown_value,
  output logic               out_trend_rising,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  // Configuration registers.
  logic               disp_sel_r;
  logic [CountW-1:0]  confirm_r;
  logic [PeriodW-1:0] numer_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // Tracking state.
  logic [SampleW-1:0] prev_r;
  logic               trend_r;
  logic [CountW-1:0]  move_r;
  logic [SampleW-1:0] peak_r;
  logic [SampleW-1:0] valley_r;
  logic [SampleW-1:0] amp_hold_r;
  logic [SampleW-1:0] freq_hold_r;
  logic [PeriodW-1:0] period_r;

  // Output register.
  logic               out_valid_r;
  logic [SampleW-1:0] out_amp_r;
  logic [SampleW-1:0] out_freq_r;
  logic [SampleW-1:0] out_shown_r;
  logic               out_trend_r;

  // Sequencer.
  tafm_state_t        state_r, state_nxt;
  logic               accept;
  logic               div_start;
  logic               load_out;
  tafm_div_stat_t     div_stat;
  logic [SampleW-1:0] div_quo;

  // Per-sample update terms.
  logic [PeriodW-1:0] period_inc;
  logic               rise_move;
  logic               fall_move;
  logic [CountW:0]    move_inc;
  logic               reach;
  logic               flip_up;
  logic               flip_down;

  // APB access; writes land on the access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_sel_r <= DisplaySelRst;
      confirm_r  <= ConfirmRst;
      numer_r    <= NumeratorRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DISPLAY_SELECT: disp_sel_r <= pwdata[0];
        REG_CONFIRM_COUNT:  confirm_r  <= pwdata[CountW-1:0];
        REG_FREQ_NUMERATOR: numer_r    <= pwdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DISPLAY_SELECT: prdata = {{(DataW-1){1'b0}}, disp_sel_r};
      REG_CONFIRM_COUNT:  prdata = {{(DataW-CountW){1'b0}}, confirm_r};
      REG_FREQ_NUMERATOR: prdata = {{(DataW-PeriodW){1'b0}}, numer_r};
      default:            prdata = '0;
    endcase
  end

  // Trend tracking terms for the incoming sample.
  always_comb begin
    period_inc = (period_r != '1) ? period_r + PeriodW'(1) : period_r;
    rise_move  = (in_sample > prev_r) && !trend_r;
    fall_move  = (in_sample < prev_r) && trend_r;
    move_inc   = {1'b0, move_r} + (CountW+1)'(1);
    reach      = (move_inc >= {1'b0, confirm_r});
    flip_up    = rise_move && reach;
    flip_down  = fall_move && reach;
  end

  assign accept = in_valid && in_ready;

  // Tracking state update on each accepted item; the frequency hold takes the divider result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      trend_r     <= 1'b1;
      move_r      <= '0;
      peak_r      <= '0;
      valley_r    <= '0;
      amp_hold_r  <= '0;
      freq_hold_r <= '0;
      period_r    <= '0;
    end else begin
      if (accept) begin
        prev_r   <= in_sample;
        period_r <= flip_up ? '0 : period_inc;
        if (rise_move) begin
          if (move_r == '0) valley_r <= in_sample;
        end
        if (fall_move) begin
          if (move_r == '0) peak_r <= in_sample;
        end
        if (rise_move || fall_move) begin
          move_r <= reach ? '0 : move_inc[CountW-1:0];
        end
        if (flip_up) trend_r <= 1'b1;
        if (flip_down) begin
          trend_r    <= 1'b0;
          amp_hold_r <= (move_r == '0) ? in_sample - valley_r : peak_r - valley_r;
        end
      end
      // The divider result lands once its last bit is in.
      if (state_r == ST_DIV && div_stat.done) begin
        freq_hold_r <= div_quo;
      end
    end
  end

  // Divider for the frequency on a flip to rising.
  tafm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .numerator (numer_r),
    .divisor   (period_inc),
    .stat      (div_stat),
    .quotient  (div_quo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = flip_up ? ST_DIV : ST_LOAD;
      end
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid && flip_up;
      end
      ST_DIV: ;
      ST_LOAD: load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register; it holds one result item until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_amp_r   <= amp_hold_r;
      out_freq_r  <= freq_hold_r;
      out_shown_r <= disp_sel_r ? freq_hold_r : amp_hold_r;
      out_trend_r <= trend_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_amplitude    = out_amp_r;
  assign out_frequency    = out_freq_r;
  assign out_shown_value  = out_shown_r;
  assign out_trend_rising = out_trend_r;

endmodule
